/* sv/slrr_pkg.sv */
`default_nettype none
package slrr_pkg;

  localparam int RAW_W = 31;
  localparam int DATA_W = 32;
  localparam int MUL_W = 15;
  localparam int PROD_W = RAW_W + MUL_W;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int WARMUP_EXTRA = 8;

  localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;
  localparam logic [DATA_W-1:0] LCG_MOD = 32'd2147483647;

  // table index is last output / (2^26 + 1)
  localparam int IDX_SHIFT = 26;
  localparam int IDX_Q_W = RAW_W - IDX_SHIFT;

  function automatic logic [IDX_Q_W-1:0] table_index(input logic [RAW_W-1:0] v);
    logic [IDX_Q_W-1:0] q0;
    logic [RAW_W-1:0] back;
    q0 = v[RAW_W-1:IDX_SHIFT];
    back = {q0, {IDX_SHIFT{1'b0}}} + {{IDX_SHIFT{1'b0}}, q0};
    if (back > v) begin
      q0 = q0 - 1'b1;
    end
    return q0;
  endfunction

endpackage
`default_nettype wire

/* sv/slrr_mulmod.sv */
`default_nettype none
// 16807 * x mod (2^31 - 1): registered product, then end-around fold
module slrr_mulmod (
  input  wire                        clk,
  input  wire                        en,
  input  wire  [slrr_pkg::RAW_W-1:0] x,
  output logic [slrr_pkg::RAW_W-1:0] y
);

  logic [slrr_pkg::PROD_W-1:0] prod_r;
  logic [slrr_pkg::DATA_W-1:0] sum;
  logic [slrr_pkg::DATA_W-1:0] red;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= x * slrr_pkg::LCG_MUL;
    end
  end

  // 2^31 is congruent to 1, so high part folds onto low part
  always_comb begin
    sum = {1'b0, prod_r[slrr_pkg::RAW_W-1:0]}
        + {{(slrr_pkg::DATA_W - slrr_pkg::MUL_W){1'b0}},
           prod_r[slrr_pkg::PROD_W-1:slrr_pkg::RAW_W]};
    if (sum >= slrr_pkg::LCG_MOD) begin
      red = sum - slrr_pkg::LCG_MOD;
    end else begin
      red = sum;
    end
    y = red[slrr_pkg::RAW_W-1:0];
  end

endmodule
`default_nettype wire

/* sv/slrr_divider.sv */
`default_nettype none
// restoring remainder, one dividend bit per cycle
module slrr_divider (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [slrr_pkg::RAW_W-1:0]  dividend,
  input  wire  [slrr_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [slrr_pkg::DATA_W-1:0] remainder
);

  localparam int CNT_W = $clog2(slrr_pkg::RAW_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [slrr_pkg::RAW_W-1:0]  dvd_r;
  logic [slrr_pkg::DATA_W-1:0] dvs_r;
  logic [slrr_pkg::DATA_W-1:0] rem_r;
  logic [slrr_pkg::DATA_W-1:0] trial;
  logic [slrr_pkg::DATA_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r[slrr_pkg::DATA_W-2:0], dvd_r[slrr_pkg::RAW_W-1]};
    if (trial >= dvs_r) begin
      rem_nxt = trial - dvs_r;
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(slrr_pkg::RAW_W);
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[slrr_pkg::RAW_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

/* sv/shuffled_lehmer_range_rng.sv */
`default_nettype none
// a valid range passes S_DFOLD, S_DIV and S_FIN before the output register loads; a bad range goes to S_FIN
// one item in work at a time, paced by the 31-step serial remainder unit; no new item until S_FIN loads the output
// warm-up: 40 generator steps (TABLE_DEPTH + 8), each a multiply and a fold state through the shared multiplier
// reset (rst_n low, synchronous) loads seed 1 and starts warm-up; a seed write restarts it
// in_tready is low during warm-up and while an item is in work
module shuffled_lehmer_range_rng #(
  parameter int TABLE_DEPTH = slrr_pkg::TABLE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // seed register
  input  wire         cfg_wr_en,
  input  wire  [30:0] cfg_wr_data,
  // draw requests
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // range_low[31:0], range_high[63:32]
  // results
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // drawn_value[31:0], raw_value[62:32], zero[63]
  output logic [0:0]  out_tuser   // range_error[0]
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int WARMUP_STEPS = TABLE_DEPTH + slrr_pkg::WARMUP_EXTRA;
  localparam int WCNT_W = $clog2(WARMUP_STEPS);
  localparam int RW = slrr_pkg::RAW_W;
  localparam int DW = slrr_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_WMUL,   // warm-up: multiply
    S_WFOLD,  // warm-up: fold and fill table
    S_IDLE,
    S_DFOLD,  // draw: new generator value, table swap
    S_DIV,    // draw: remainder by span
    S_FIN     // draw: load output register
  } state_t;

  state_t            state_r;
  logic [WCNT_W-1:0] wcnt_r;
  logic [RW-1:0]     lehmer_r;
  logic [RW-1:0]     last_out_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DW-1:0]     lo_r;
  logic [DW-1:0]     span_r;
  logic              err_r;
  logic              out_valid_r;
  logic [63:0]       out_data_r;
  logic              out_err_r;

  // shuffle table
  logic [RW-1:0]     table_mem [TABLE_DEPTH];
  logic [RW-1:0]     rd_data_r;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;

  logic              in_acc;
  logic signed [DW:0] diff;
  logic              bad_range;
  logic              mul_en;
  logic [RW-1:0]     mul_y;
  logic              div_start;
  logic              div_done;
  logic [DW-1:0]     div_rem;
  logic              out_free;
  logic              out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // span - 1 with a sign bit; bad if negative or at least 2^31
  assign diff = $signed({in_tdata[63], in_tdata[63:32]})
              - $signed({in_tdata[31], in_tdata[31:0]});
  assign bad_range = diff[DW] | diff[DW-1];

  assign mul_en    = (state_r == S_WMUL) || (in_acc && !bad_range);
  assign div_start = (state_r == S_DFOLD);
  assign out_free  = !out_valid_r || out_tready;
  // output register takes a new item this cycle
  assign out_load  = (state_r == S_FIN) && out_free && !cfg_wr_en;

  // index from the previous output picks the entry that goes out
  assign rd_idx = IDX_W'(slrr_pkg::table_index(last_out_r));

  // warm-up fills the table from the top down; a draw refills the used entry
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx_r;
    if (state_r == S_WFOLD) begin
      wr_en  = (wcnt_r < WCNT_W'(TABLE_DEPTH));
      wr_idx = wcnt_r[IDX_W-1:0];
    end else if (state_r == S_DFOLD) begin
      wr_en  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= mul_y;
    end
    rd_data_r <= table_mem[rd_idx];
  end

  slrr_mulmod u_mulmod (
    .clk (clk),
    .en  (mul_en),
    .x   (lehmer_r),
    .y   (mul_y)
  );

  slrr_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rd_data_r),
    .divisor   (span_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WMUL;
      wcnt_r      <= WCNT_W'(WARMUP_STEPS - 1);
      lehmer_r    <= RW'(1);
      last_out_r  <= '0;
      idx_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_err_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        // zero seed acts as one
        state_r  <= S_WMUL;
        wcnt_r   <= WCNT_W'(WARMUP_STEPS - 1);
        lehmer_r <= (cfg_wr_data == '0) ? RW'(1) : cfg_wr_data;
      end else begin
        unique case (state_r)
          S_WMUL: begin
            state_r <= S_WFOLD;
          end
          S_WFOLD: begin
            lehmer_r <= mul_y;
            if (wcnt_r == '0) begin
              last_out_r <= mul_y;
              state_r    <= S_IDLE;
            end else begin
              wcnt_r  <= wcnt_r - 1'b1;
              state_r <= S_WMUL;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              lo_r   <= in_tdata[31:0];
              span_r <= diff[DW-1:0] + DW'(1);
              idx_r  <= rd_idx;
              err_r  <= bad_range;
              // bad range leaves generator and table untouched
              state_r <= bad_range ? S_FIN : S_DFOLD;
            end
          end
          S_DFOLD: begin
            lehmer_r   <= mul_y;
            last_out_r <= rd_data_r;
            state_r    <= S_DIV;
          end
          S_DIV: begin
            if (div_done) begin
              state_r <= S_FIN;
            end
          end
          S_FIN: begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_err_r   <= err_r;
              if (err_r) begin
                out_data_r <= '0;
              end else begin
                out_data_r <= {1'b0, last_out_r, lo_r + div_rem};
              end
              state_r <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

endmodule
`default_nettype wire
